/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the base64 decoder checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, quiet in reset
`define B64D_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("b64d assertion failed");

// Next-cycle implication, sampled on the rising clock edge, quiet in reset
`define B64D_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("b64d assertion failed");

`endif

/* rtl/b64d_pkg.sv */
// ----------------------------------------------------------------------------
// Base64 decoder package
// Character codes, sextet offsets and the structs that carry the outputs of
// the decoder's classifier and accumulator.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int CharWidth  = 8;
  localparam int SextWidth  = 6;
  localparam int CountWidth = 3;

  // Alphabet boundaries
  localparam logic [CharWidth-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CharWidth-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CharWidth-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CharWidth-1:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [CharWidth-1:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [CharWidth-1:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [CharWidth-1:0] CHAR_PLUS    = 8'h2B;
  localparam logic [CharWidth-1:0] CHAR_MINUS   = 8'h2D;
  localparam logic [CharWidth-1:0] CHAR_SLASH   = 8'h2F;
  localparam logic [CharWidth-1:0] CHAR_UNDER   = 8'h5F;

  // Skipped characters
  localparam logic [CharWidth-1:0] CHAR_PAD     = 8'h3D;
  localparam logic [CharWidth-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CharWidth-1:0] CHAR_WS_LO   = 8'h09;
  localparam logic [CharWidth-1:0] CHAR_WS_HI   = 8'h0D;

  // Sextet values
  localparam logic [SextWidth-1:0] SEXT_LOWER_BASE = 6'd26;
  localparam logic [SextWidth-1:0] SEXT_DIGIT_BASE = 6'd52;
  localparam logic [SextWidth-1:0] SEXT_PLUS       = 6'd62;
  localparam logic [SextWidth-1:0] SEXT_SLASH      = 6'd63;

  // Classification of one character
  typedef struct packed {
    logic [SextWidth-1:0] sextet;
    logic                 is_valid;
    logic                 is_skip;
  } b64d_class_t;

  // One decoded result
  typedef struct packed {
    logic [CharWidth-1:0] byte_out;
    logic                 byte_valid;
    logic                 bad_char;
    logic                 end_out;
  } b64d_result_t;

endpackage

/* rtl/b64d_stream_if.sv */
// ----------------------------------------------------------------------------
// Base64 decoder stream interfaces
// Valid/ready channels for text characters in and decoded bytes out.
// ----------------------------------------------------------------------------
interface b64d_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_text;

  modport source (output valid, char_in, end_of_text, input ready);
  modport sink   (input valid, char_in, end_of_text, output ready);
endinterface

interface b64d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       byte_valid;
  logic       bad_char;
  logic       end_out;

  modport source (output valid, byte_out, byte_valid, bad_char, end_out, input ready);
  modport sink   (input valid, byte_out, byte_valid, bad_char, end_out, output ready);
endinterface

/* rtl/base64_stream_decoder.sv */
// ----------------------------------------------------------------------------
// Base64 stream decoder
// Decodes a stream of base64 text, standard or URL-safe, one character per
// beat, giving exactly one result beat per character.
// ----------------------------------------------------------------------------
// Each accepted character gives one result beat, held first in the input
// register and then in the output register, with the character
// classification and bit accumulation between them. A new character is taken
// every cycle while the output side keeps taking results; the input register
// and output register together let a character enter while a finished
// result still waits. byte_out is zero whenever byte_valid is low. An invalid
// character holds bad_char high and byte_valid low until the beat that
// carries end_of_text, after which leftover bits and the error are cleared.
module base64_stream_decoder (
  input  logic               clk,
  input  logic               rst,
  b64d_char_if.sink          in_chan,
  b64d_byte_if.source        out_chan
);

  logic                                 in_valid;
  logic [b64d_pkg::CharWidth-1:0]       char_q;
  logic                                 end_q;
  logic                                 out_valid;
  b64d_pkg::b64d_result_t               out_res;
  logic                                 out_free;
  logic                                 advance;
  b64d_pkg::b64d_class_t                cls;
  b64d_pkg::b64d_result_t               res;

  // Move a beat on when the output register is empty or being emptied
  assign out_free      = !out_valid || out_chan.ready;
  assign advance       = in_valid && out_free;
  assign in_chan.ready = !in_valid || out_free;

  // Hold the accepted character
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      char_q <= in_chan.char_in;
      end_q  <= in_chan.end_of_text;
    end
  end

  b64d_classify u_classify (
    .char_in (char_q),
    .cls     (cls)
  );

  b64d_accum u_accum (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .cls      (cls),
    .end_mark (end_q),
    .res      (res)
  );

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign out_chan.valid      = out_valid;
  assign out_chan.byte_out   = out_res.byte_out;
  assign out_chan.byte_valid = out_res.byte_valid;
  assign out_chan.bad_char   = out_res.bad_char;
  assign out_chan.end_out    = out_res.end_out;

endmodule

/* rtl/b64d_classify.sv */
// ----------------------------------------------------------------------------
// Base64 character classifier
// Maps one character code to its sextet, or flags it as skipped or invalid.
// Both the standard and the URL-safe alphabets are recognised.
// ----------------------------------------------------------------------------
module b64d_classify (
  input  logic [b64d_pkg::CharWidth-1:0] char_in,
  output b64d_pkg::b64d_class_t          cls
);

  logic is_upper;
  logic is_lower;
  logic is_digit;
  logic is_plus;
  logic is_slash;
  logic is_skip;
  logic [b64d_pkg::CharWidth-1:0] upper_off;
  logic [b64d_pkg::CharWidth-1:0] lower_off;
  logic [b64d_pkg::CharWidth-1:0] digit_off;

  // Decode the alphabet ranges
  assign is_upper = (char_in >= b64d_pkg::CHAR_UPPER_A) && (char_in <= b64d_pkg::CHAR_UPPER_Z);
  assign is_lower = (char_in >= b64d_pkg::CHAR_LOWER_A) && (char_in <= b64d_pkg::CHAR_LOWER_Z);
  assign is_digit = (char_in >= b64d_pkg::CHAR_DIGIT_0) && (char_in <= b64d_pkg::CHAR_DIGIT_9);
  assign is_plus  = (char_in == b64d_pkg::CHAR_PLUS)  || (char_in == b64d_pkg::CHAR_MINUS);
  assign is_slash = (char_in == b64d_pkg::CHAR_SLASH) || (char_in == b64d_pkg::CHAR_UNDER);

  // Padding and whitespace are skipped
  assign is_skip  = (char_in == b64d_pkg::CHAR_PAD) || (char_in == b64d_pkg::CHAR_SPACE) ||
                    ((char_in >= b64d_pkg::CHAR_WS_LO) && (char_in <= b64d_pkg::CHAR_WS_HI));

  assign upper_off = char_in - b64d_pkg::CHAR_UPPER_A;
  assign lower_off = char_in - b64d_pkg::CHAR_LOWER_A;
  assign digit_off = char_in - b64d_pkg::CHAR_DIGIT_0;

  // Select the sextet value and the class flags
  always_comb begin
    cls.sextet = '0;
    if (is_upper) begin
      cls.sextet = upper_off[b64d_pkg::SextWidth-1:0];
    end else if (is_lower) begin
      cls.sextet = lower_off[b64d_pkg::SextWidth-1:0] + b64d_pkg::SEXT_LOWER_BASE;
    end else if (is_digit) begin
      cls.sextet = digit_off[b64d_pkg::SextWidth-1:0] + b64d_pkg::SEXT_DIGIT_BASE;
    end else if (is_plus) begin
      cls.sextet = b64d_pkg::SEXT_PLUS;
    end else if (is_slash) begin
      cls.sextet = b64d_pkg::SEXT_SLASH;
    end
    cls.is_valid = is_upper || is_lower || is_digit || is_plus || is_slash;
    cls.is_skip  = is_skip;
  end

endmodule

/* rtl/b64d_accum.sv */
// ----------------------------------------------------------------------------
// Base64 bit accumulator
// Holds the leftover bits, their count and the sticky error flag, and forms
// one result from each classified character.
// ----------------------------------------------------------------------------
module b64d_accum (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  b64d_pkg::b64d_class_t cls,
  input  logic                  end_mark,
  output b64d_pkg::b64d_result_t res
);

  localparam int AccWidth   = 2 * b64d_pkg::SextWidth;
  localparam int TotalWidth = b64d_pkg::CountWidth + 1;

  logic [b64d_pkg::SextWidth-1:0]  leftover_bits;
  logic [b64d_pkg::CountWidth-1:0] leftover_count;
  logic                            error_seen;

  logic [b64d_pkg::SextWidth-1:0]  leftover_bits_next;
  logic [b64d_pkg::CountWidth-1:0] leftover_count_next;
  logic                            error_seen_next;

  logic                            live;
  logic                            take;
  logic [AccWidth-1:0]             acc;
  logic [TotalWidth-1:0]           total;
  logic                            have_byte;
  logic [b64d_pkg::CountWidth-1:0] shift;
  logic [AccWidth-1:0]             shifted;
  logic [b64d_pkg::SextWidth:0]    keep_mask;

  // Append the sextet and see whether a full byte is present
  assign live      = !error_seen && !cls.is_skip;
  assign take      = live && cls.is_valid;
  assign acc       = {leftover_bits, cls.sextet};
  assign total     = {1'b0, leftover_count} + TotalWidth'(b64d_pkg::SextWidth);
  assign have_byte = total[TotalWidth-1];
  assign shift     = total[b64d_pkg::CountWidth-1:0];
  assign shifted   = acc >> shift;
  assign keep_mask = ((b64d_pkg::SextWidth+1)'(1) << shift) - (b64d_pkg::SextWidth+1)'(1);

  // Form the result for this beat
  always_comb begin
    res.byte_valid = take && have_byte;
    res.byte_out   = res.byte_valid ? shifted[b64d_pkg::CharWidth-1:0] : '0;
    res.bad_char   = error_seen_next;
    res.end_out    = end_mark;
  end

  // Work out the state after this beat
  always_comb begin
    error_seen_next     = error_seen || (live && !cls.is_valid);
    leftover_bits_next  = leftover_bits;
    leftover_count_next = leftover_count;
    if (take) begin
      if (have_byte) begin
        leftover_bits_next  = acc[b64d_pkg::SextWidth-1:0] &
                              keep_mask[b64d_pkg::SextWidth-1:0];
        leftover_count_next = shift;
      end else begin
        leftover_bits_next  = acc[b64d_pkg::SextWidth-1:0];
        leftover_count_next = total[b64d_pkg::CountWidth-1:0];
      end
    end
  end

  // Advance the state; drop everything at the end of the string
  always_ff @(posedge clk) begin
    if (rst) begin
      leftover_bits  <= '0;
      leftover_count <= '0;
      error_seen     <= 1'b0;
    end else if (advance) begin
      if (end_mark) begin
        leftover_bits  <= '0;
        leftover_count <= '0;
        error_seen     <= 1'b0;
      end else begin
        leftover_bits  <= leftover_bits_next;
        leftover_count <= leftover_count_next;
        error_seen     <= error_seen_next;
      end
    end
  end

endmodule

/* rtl/b64d_checker.sv */
// ----------------------------------------------------------------------------
// Base64 decoder checker
// Port-level assertions on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b64d_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] byte_out,
  input logic       byte_valid,
  input logic       bad_char,
  input logic       end_out
);

  // A stalled result beat stays put
  `B64D_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(byte_out) && $stable(byte_valid) && $stable(bad_char) && $stable(end_out))

  // No byte is given while the string is in error
  `B64D_ASSERT_IMP(a_no_byte_in_error, clk, rst, out_valid, !(byte_valid && bad_char))

  // An empty byte slot carries zero
  `B64D_ASSERT_IMP(a_zero_when_empty, clk, rst, out_valid && !byte_valid, byte_out == 8'h00)

  // With nothing waiting at the output, a character is always taken
  `B64D_ASSERT_IMP(a_ready_when_drained, clk, rst, !out_valid, in_ready)

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .byte_out   (out_chan.byte_out),
  .byte_valid (out_chan.byte_valid),
  .bad_char   (out_chan.bad_char),
  .end_out    (out_chan.end_out)
);

/* dv/base64_stream_decoder_tb.sv */
// ----------------------------------------------------------------------------
// Base64 stream decoder testbench
// Sends text characters through the decoder and checks every result beat,
// field by field, against a cycle-free decode of the same characters. It uses
// directed edge cases, then random strings in both alphabets with padding and
// whitespace, corrupted strings and raw noise, under bursty input and a
// stalling output.
// ----------------------------------------------------------------------------
module base64_stream_decoder_tb;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int MAX_REPORTS     = 100;
  localparam int CHAR_W          = b64d_pkg::CharWidth;
  localparam int SEXT_W          = b64d_pkg::SextWidth;
  localparam int COUNT_W         = b64d_pkg::CountWidth;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              eot;
  } text_beat_t;

  logic clk;
  logic rst;

  b64d_char_if char_bus ();
  b64d_byte_if byte_bus ();

  base64_stream_decoder DUT (
    .clk      (clk),
    .rst      (rst),
    .in_chan  (char_bus.sink),
    .out_chan (byte_bus.source)
  );

  // Pending characters and the decoded results still owed by the block
  text_beat_t             pending_chars[$];
  b64d_pkg::b64d_result_t expected_results[$];

  // Decoder state as predicted
  logic [SEXT_W-1:0]  held_bits  = '0;
  logic [COUNT_W-1:0] held_count = '0;
  logic               text_error = 1'b0;

  // Traffic shaping
  bit full_rate     = 1'b0;
  bit hold_off_req  = 1'b0;
  int stall_pct     = 20;
  int burst_left    = 0;
  int gap_left      = 0;
  int stall_left    = 0;
  int hold_cnt      = 0;

  // Counters
  int queued_total   = 0;
  int accepted_count = 0;
  int result_count   = 0;
  int byte_count     = 0;
  int bad_count      = 0;
  int text_count     = 0;
  int mismatch_count = 0;

  text_beat_t             beat;
  b64d_pkg::b64d_result_t want;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Sort one character into alphabet, skipped or invalid
  function automatic b64d_pkg::b64d_class_t classify_char(input logic [CHAR_W-1:0] c);
    b64d_pkg::b64d_class_t k;
    k = '0;
    if (c == b64d_pkg::CHAR_PAD || c == b64d_pkg::CHAR_SPACE ||
        (c >= b64d_pkg::CHAR_WS_LO && c <= b64d_pkg::CHAR_WS_HI)) begin
      k.is_skip = 1'b1;
    end else if (c >= b64d_pkg::CHAR_UPPER_A && c <= b64d_pkg::CHAR_UPPER_Z) begin
      k.is_valid = 1'b1;
      k.sextet   = SEXT_W'(c - b64d_pkg::CHAR_UPPER_A);
    end else if (c >= b64d_pkg::CHAR_LOWER_A && c <= b64d_pkg::CHAR_LOWER_Z) begin
      k.is_valid = 1'b1;
      k.sextet   = b64d_pkg::SEXT_LOWER_BASE + SEXT_W'(c - b64d_pkg::CHAR_LOWER_A);
    end else if (c >= b64d_pkg::CHAR_DIGIT_0 && c <= b64d_pkg::CHAR_DIGIT_9) begin
      k.is_valid = 1'b1;
      k.sextet   = b64d_pkg::SEXT_DIGIT_BASE + SEXT_W'(c - b64d_pkg::CHAR_DIGIT_0);
    end else if (c == b64d_pkg::CHAR_PLUS || c == b64d_pkg::CHAR_MINUS) begin
      k.is_valid = 1'b1;
      k.sextet   = b64d_pkg::SEXT_PLUS;
    end else if (c == b64d_pkg::CHAR_SLASH || c == b64d_pkg::CHAR_UNDER) begin
      k.is_valid = 1'b1;
      k.sextet   = b64d_pkg::SEXT_SLASH;
    end
    return k;
  endfunction

  // Decode one character, advance the held bits and return the result beat
  function automatic b64d_pkg::b64d_result_t decode_char(input logic [CHAR_W-1:0] c,
                                                         input logic eot);
    b64d_pkg::b64d_class_t  k;
    b64d_pkg::b64d_result_t r;
    logic [11:0]            acc;
    logic [3:0]             total;
    k = classify_char(c);
    r = '0;
    if (!text_error && !k.is_skip) begin
      if (!k.is_valid) begin
        text_error = 1'b1;
      end else begin
        acc   = {held_bits, k.sextet};
        total = 4'(held_count) + 4'd6;
        if (total >= 4'd8) begin
          total        = total - 4'd8;
          r.byte_out   = CHAR_W'(acc >> total);
          r.byte_valid = 1'b1;
          acc          = acc & ((12'd1 << total) - 12'd1);
        end
        held_bits  = acc[SEXT_W-1:0];
        held_count = total[COUNT_W-1:0];
      end
    end
    r.bad_char = text_error;
    r.end_out  = eot;
    // End of text drops leftover bits and the error
    if (eot) begin
      held_bits  = '0;
      held_count = '0;
      text_error = 1'b0;
    end
    return r;
  endfunction

  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("MISMATCH at result %0d: %s", result_count, what);
  endtask

  function automatic void put_char(input logic [CHAR_W-1:0] c, input logic eot);
    text_beat_t item;
    item.ch  = c;
    item.eot = eot;
    pending_chars.insert(pending_chars.size(), item);
    queued_total++;
  endfunction

  // Encode random bytes as one string; alphabet 0 standard, 1 URL-safe, 2 mixed
  task automatic queue_string(input int nbytes, input int alphabet, input bit padded,
                              input int ws_pct, input bit corrupt);
    logic [CHAR_W-1:0]     chars[$];
    logic [15:0]           acc;
    logic [SEXT_W-1:0]     sx;
    logic [CHAR_W-1:0]     c;
    b64d_pkg::b64d_class_t k;
    int                    nbits;
    bit                    url;
    acc   = '0;
    nbits = 0;
    for (int i = 0; i <= nbytes; i++) begin
      if (i < nbytes) begin
        acc   = {acc[7:0], 8'($urandom)};
        nbits = nbits + 8;
      end else if (nbits > 0) begin
        // pad the tail sextet with zero bits
        acc   = acc << (6 - nbits);
        nbits = 6;
      end
      while (nbits >= 6) begin
        nbits = nbits - 6;
        sx    = SEXT_W'(acc >> nbits);
        url   = (alphabet == 2) ? bit'($urandom_range(0, 1)) : (alphabet == 1);
        if (sx < b64d_pkg::SEXT_LOWER_BASE)
          c = b64d_pkg::CHAR_UPPER_A + sx;
        else if (sx < b64d_pkg::SEXT_DIGIT_BASE)
          c = b64d_pkg::CHAR_LOWER_A + (sx - b64d_pkg::SEXT_LOWER_BASE);
        else if (sx < b64d_pkg::SEXT_PLUS)
          c = b64d_pkg::CHAR_DIGIT_0 + (sx - b64d_pkg::SEXT_DIGIT_BASE);
        else if (sx == b64d_pkg::SEXT_PLUS)
          c = url ? b64d_pkg::CHAR_MINUS : b64d_pkg::CHAR_PLUS;
        else
          c = url ? b64d_pkg::CHAR_UNDER : b64d_pkg::CHAR_SLASH;
        chars.insert(chars.size(), c);
      end
    end
    if (padded)
      while (chars.size() % 4 != 0) chars.insert(chars.size(), b64d_pkg::CHAR_PAD);
    if (corrupt) begin
      do begin
        c = 8'($urandom_range(0, 255));
        k = classify_char(c);
      end while (k.is_valid || k.is_skip);
      chars.insert($urandom_range(0, chars.size()), c);
    end
    if (chars.size() == 0) chars.insert(0, b64d_pkg::CHAR_SPACE);
    foreach (chars[i]) begin
      if (int'($urandom_range(0, 99)) < ws_pct) begin
        c = ($urandom_range(0, 5) == 5) ? b64d_pkg::CHAR_SPACE :
                                          b64d_pkg::CHAR_WS_LO + 8'($urandom_range(0, 4));
        put_char(c, 1'b0);
      end
      put_char(chars[i], i == chars.size() - 1);
    end
  endtask

  // Mostly well-formed strings, some corrupted, some raw noise
  task automatic queue_random_text(input int n_items);
    int stop_at;
    int pick;
    int nbytes;
    stop_at = queued_total + n_items;
    while (queued_total < stop_at) begin
      pick   = $urandom_range(0, 99);
      nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 9);
      if (pick < 85) begin
        queue_string(nbytes, $urandom_range(0, 2), bit'($urandom_range(0, 1)),
                     ($urandom_range(0, 3) == 0) ? 20 : 0, pick >= 70);
      end else begin
        repeat ($urandom_range(1, 8))
          put_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end
    end
  endtask

  // Wait until nothing is queued, offered or owed
  task automatic wait_for_drain;
    while (pending_chars.size() != 0 || char_bus.valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // Character driver: bursts with random gaps, prediction on each accepted beat
  always @(posedge clk) begin
    if (rst) begin
      char_bus.valid       <= 1'b0;
      char_bus.char_in     <= '0;
      char_bus.end_of_text <= 1'b0;
      held_bits  = '0;
      held_count = '0;
      text_error = 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (char_bus.valid && char_bus.ready) begin
        expected_results.insert(expected_results.size(),
                                decode_char(char_bus.char_in, char_bus.end_of_text));
        accepted_count++;
      end
      if (!char_bus.valid || char_bus.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          char_bus.valid <= 1'b0;
        end else if (pending_chars.size() == 0) begin
          char_bus.valid <= 1'b0;
        end else begin
          beat = pending_chars.pop_front();
          char_bus.valid       <= 1'b1;
          char_bus.char_in     <= beat.ch;
          char_bus.end_of_text <= beat.eot;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            if (full_rate || $urandom_range(0, 2) == 0) gap_left = 0;
            else gap_left = $urandom_range(1, 10);
          end
        end
      end
    end
  end

  // Result receiver: long hold-off on request, otherwise random stalls
  always @(posedge clk) begin
    if (rst) begin
      byte_bus.ready <= 1'b0;
      stall_left = 0;
      hold_cnt   = 0;
    end else if (hold_off_req) begin
      byte_bus.ready <= 1'b0;
      if (hold_cnt >= HOLD_OFF_CYCLES) begin
        hold_off_req = 1'b0;
        hold_cnt     = 0;
      end else begin
        hold_cnt++;
      end
    end else if (full_rate) begin
      byte_bus.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      byte_bus.ready <= 1'b0;
    end else begin
      byte_bus.ready <= 1'b1;
      if (int'($urandom_range(0, 99)) < stall_pct) stall_left = $urandom_range(1, 8);
    end
  end

  // Result monitor: compare each accepted beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst && byte_bus.valid === 1'b1 && byte_bus.ready) begin
      if (expected_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result beat, byte_out %02h", byte_bus.byte_out));
      end else begin
        want = expected_results.pop_front();
        if (byte_bus.byte_out !== want.byte_out)
          note_mismatch($sformatf("byte_out %02h, want %02h", byte_bus.byte_out, want.byte_out));
        if (byte_bus.byte_valid !== want.byte_valid)
          note_mismatch($sformatf("byte_valid %b, want %b", byte_bus.byte_valid,
                                  want.byte_valid));
        if (byte_bus.bad_char !== want.bad_char)
          note_mismatch($sformatf("bad_char %b, want %b", byte_bus.bad_char, want.bad_char));
        if (byte_bus.end_out !== want.end_out)
          note_mismatch($sformatf("end_out %b, want %b", byte_bus.end_out, want.end_out));
        if (want.byte_valid) byte_count++;
        if (want.bad_char)   bad_count++;
        if (want.end_out)    text_count++;
      end
      result_count++;
    end
  end

  initial begin
    rst                  = 1'b1;
    char_bus.valid       = 1'b0;
    char_bus.char_in     = '0;
    char_bus.end_of_text = 1'b0;
    byte_bus.ready       = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: a plain quantum, alphabet extremes in both forms, skipped
    // characters, error suppression, end of text on a bad character and on
    // leftover bits
    put_char("T", 1'b0); put_char("W", 1'b0); put_char("F", 1'b0); put_char("u", 1'b1);
    put_char(b64d_pkg::CHAR_UPPER_A, 1'b0); put_char(b64d_pkg::CHAR_UPPER_Z, 1'b0);
    put_char(b64d_pkg::CHAR_LOWER_A, 1'b0); put_char(b64d_pkg::CHAR_LOWER_Z, 1'b0);
    put_char(b64d_pkg::CHAR_DIGIT_0, 1'b0); put_char(b64d_pkg::CHAR_DIGIT_9, 1'b0);
    put_char(b64d_pkg::CHAR_PLUS, 1'b0);    put_char(b64d_pkg::CHAR_MINUS, 1'b0);
    put_char(b64d_pkg::CHAR_SLASH, 1'b0);   put_char(b64d_pkg::CHAR_UNDER, 1'b0);
    put_char(b64d_pkg::CHAR_PAD, 1'b0);     put_char(b64d_pkg::CHAR_SPACE, 1'b0);
    put_char(b64d_pkg::CHAR_WS_LO, 1'b0);   put_char(b64d_pkg::CHAR_WS_HI, 1'b0);
    put_char(b64d_pkg::CHAR_WS_LO - 8'd1, 1'b0);
    put_char("Q", 1'b0);
    put_char(8'hFF, 1'b1);
    put_char("Q", 1'b0); put_char("Q", 1'b1);
    put_char(8'h00, 1'b1);
    put_char(b64d_pkg::CHAR_WS_HI + 8'd1, 1'b1);
    wait_for_drain;

    // Random with light stalls; long receiver hold-off part way through
    stall_pct = 20;
    queue_random_text(600);
    while (pending_chars.size() > 400) @(posedge clk);
    @(negedge clk);
    hold_off_req = 1'b1;
    wait_for_drain;

    // Random at full rate on both sides
    full_rate = 1'b1;
    queue_random_text(300);
    wait_for_drain;

    // Random with heavy output stalls
    full_rate = 1'b0;
    stall_pct = 60;
    queue_random_text(650);
    wait_for_drain;

    repeat (10) @(posedge clk);
    if (expected_results.size() != 0)
      note_mismatch($sformatf("%0d result beats never arrived", expected_results.size()));
    $display("Checked %0d result beats for %0d characters sent.", result_count,
             accepted_count);
    $display("Seen %0d decoded bytes, %0d beats flagged bad, %0d strings ended.",
             byte_count, bad_count, text_count);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
